@@ rtl/cfd_pkg.sv @@
package cfd_pkg;

   localparam int FRAME_LENGTH = 11;
   localparam int COUNT_WIDTH  = $clog2(FRAME_LENGTH + 1);
   localparam int STORE_DEPTH  = FRAME_LENGTH - 1;

   localparam int BYTE_WIDTH    = 8;
   localparam int CSR_IDX_WIDTH = 2;
   localparam int FWD_WIDTH     = 22;
   localparam int TURN_WIDTH    = 21;
   localparam int POSE_WIDTH    = 16;

   localparam logic [BYTE_WIDTH-1:0] HEADER_RESET = 8'd123;
   localparam logic [BYTE_WIDTH-1:0] TAIL_RESET   = 8'd125;

   localparam logic signed [FWD_WIDTH-1:0]  FWD_SCALE  = 22'sd45;
   localparam logic signed [TURN_WIDTH-1:0] TURN_SCALE = 21'sd25;

   typedef enum logic [1:0] {
      KIND_STOP = 2'd0,
      KIND_MOVE = 2'd1,
      KIND_POSE = 2'd2
   } command_kind_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      REG_RECEIVE_ENABLE = 2'd0,
      REG_HEADER_BYTE    = 2'd1,
      REG_TAIL_BYTE      = 2'd2
   } reg_index_type;

endpackage

@@ rtl/cfd_if.sv @@
interface cfd_req_if;
   logic                            valid;
   logic                            ready;
   logic [cfd_pkg::BYTE_WIDTH-1:0]  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfd_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [1:0]                             command_kind;
   logic signed [cfd_pkg::FWD_WIDTH-1:0]   forward_speed_hundredths;
   logic signed [cfd_pkg::TURN_WIDTH-1:0]  turn_speed_hundredths;
   logic signed [cfd_pkg::POSE_WIDTH-1:0]  pose_first;
   logic signed [cfd_pkg::POSE_WIDTH-1:0]  pose_second;

   modport source (output valid, output command_kind, output forward_speed_hundredths,
                   output turn_speed_hundredths, output pose_first, output pose_second,
                   input ready);
   modport sink   (input valid, input command_kind, input forward_speed_hundredths,
                   input turn_speed_hundredths, input pose_first, input pose_second,
                   output ready);
endinterface

interface cfd_csr_if;
   logic                               valid;
   logic                               ready;
   logic [cfd_pkg::CSR_IDX_WIDTH-1:0]  index;
   logic [cfd_pkg::BYTE_WIDTH-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/command_frame_deframer_top.sv @@
// a result beat appears on rsp in the cycle after the final (eleventh) frame byte
// throughput: one received byte per cycle, but the closing byte waits while a result
//   is stalled; the frame check and command decode sit between the byte store and the
//   result register, so a valid frame takes eleven received bytes
// reset (synchronous, active high): byte count and result valid cleared, receive
//   disabled, header and tail values back to 123 and 125
module command_frame_deframer_top (
   input  logic            clock,
   input  logic            reset,
   cfd_req_if.sink         req_if,
   cfd_rsp_if.source       rsp_if,
   cfd_csr_if.sink         csr_if
);

   // configuration registers
   logic                               enable_ff, enable_in;
   logic [cfd_pkg::BYTE_WIDTH-1:0]     header_ff, header_in;
   logic [cfd_pkg::BYTE_WIDTH-1:0]     tail_ff, tail_in;

   // frame assembly state
   logic [cfd_pkg::COUNT_WIDTH-1:0]    count_ff, count_in;
   logic [cfd_pkg::BYTE_WIDTH-1:0]     frame_ff [cfd_pkg::STORE_DEPTH];

   // result register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [1:0]                         kind_ff, kind_in;
   logic signed [cfd_pkg::FWD_WIDTH-1:0]  fwd_ff, fwd_in;
   logic signed [cfd_pkg::TURN_WIDTH-1:0] turn_ff, turn_in;
   logic signed [cfd_pkg::POSE_WIDTH-1:0] pose_a_ff, pose_a_in;
   logic signed [cfd_pkg::POSE_WIDTH-1:0] pose_b_ff, pose_b_in;

   logic                               byte_beat;
   logic                               last_byte;
   logic                               frame_done;
   logic                               frame_good;
   logic [cfd_pkg::BYTE_WIDTH-1:0]     rx_byte;
   logic [cfd_pkg::BYTE_WIDTH-1:0]     check;
   logic                               pose_zero;
   logic signed [cfd_pkg::POSE_WIDTH-1:0] word_fwd, word_turn;
   logic signed [cfd_pkg::FWD_WIDTH-1:0]  fwd_ext;
   logic signed [cfd_pkg::TURN_WIDTH-1:0] turn_ext;

   assign rx_byte = req_if.rx_byte;

   // the byte that closes a frame may produce a result, so it waits for a free
   // result register; every other byte is taken even while a result is stalled
   assign last_byte   = (count_ff == cfd_pkg::COUNT_WIDTH'(cfd_pkg::FRAME_LENGTH - 1));
   assign req_if.ready = !(enable_ff && last_byte && rsp_valid_ff && !rsp_if.ready);
   assign byte_beat   = req_if.valid && req_if.ready && enable_ff;
   assign frame_done  = byte_beat && last_byte;

   // configuration writes are always taken; unknown indexes are dropped
   assign csr_if.ready = 1'b1;

   always_comb begin
      enable_in = enable_ff;
      header_in = header_ff;
      tail_in   = tail_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            cfd_pkg::REG_RECEIVE_ENABLE: enable_in = csr_if.data[0];
            cfd_pkg::REG_HEADER_BYTE:    header_in = csr_if.data;
            cfd_pkg::REG_TAIL_BYTE:      tail_in   = csr_if.data;
            default: ;
         endcase
      end
   end

   // byte counter: idle until a header byte, wraps to zero once the frame is full
   always_comb begin
      count_in = count_ff;
      if (byte_beat) begin
         if (last_byte) begin
            count_in = '0;
         end else if (rx_byte == header_ff || count_ff != '0) begin
            count_in = count_ff + 1'b1;
         end else begin
            count_in = '0;
         end
      end
   end

   // frame check: bytes 0..9 come from the store, the tail is the byte on the bus
   always_comb begin
      check = '0;
      for (int i = 0; i < 9; i++) begin
         check = check ^ frame_ff[i];
      end
   end

   assign frame_good = (rx_byte == tail_ff) && (frame_ff[9] == check);
   assign pose_zero  = (frame_ff[5] == '0) && (frame_ff[6] == '0) &&
                       (frame_ff[7] == '0) && (frame_ff[8] == '0);

   // big-endian signed words, scaled by constants (shift-add after synthesis)
   assign word_fwd  = {frame_ff[1], frame_ff[2]};
   assign word_turn = {frame_ff[3], frame_ff[4]};
   assign fwd_ext   = cfd_pkg::FWD_WIDTH'(word_fwd);
   assign turn_ext  = cfd_pkg::TURN_WIDTH'(word_turn);

   always_comb begin
      kind_in   = kind_ff;
      fwd_in    = fwd_ff;
      turn_in   = turn_ff;
      pose_a_in = pose_a_ff;
      pose_b_in = pose_b_ff;
      if (frame_done && frame_good) begin
         kind_in   = cfd_pkg::KIND_STOP;
         fwd_in    = '0;
         turn_in   = '0;
         pose_a_in = '0;
         pose_b_in = '0;
         priority if (check == header_ff) begin
            kind_in = cfd_pkg::KIND_STOP;
         end else if (pose_zero) begin
            kind_in = cfd_pkg::KIND_MOVE;
            fwd_in  = fwd_ext * cfd_pkg::FWD_SCALE;
            turn_in = turn_ext * cfd_pkg::TURN_SCALE;
         end else begin
            kind_in   = cfd_pkg::KIND_POSE;
            pose_a_in = {frame_ff[5], frame_ff[6]};
            pose_b_in = {frame_ff[7], frame_ff[8]};
         end
      end
   end

   // result valid: set by a good frame, cleared when the beat is taken
   assign rsp_valid_in = (frame_done && frame_good) || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         header_ff    <= cfd_pkg::HEADER_RESET;
         tail_ff      <= cfd_pkg::TAIL_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         header_ff    <= header_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // byte store: written at the current count, tail byte is never stored
   always_ff @(posedge clock) begin
      for (int i = 0; i < cfd_pkg::STORE_DEPTH; i++) begin
         if (byte_beat && count_ff == cfd_pkg::COUNT_WIDTH'(i)) begin
            frame_ff[i] <= rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      fwd_ff    <= fwd_in;
      turn_ff   <= turn_in;
      pose_a_ff <= pose_a_in;
      pose_b_ff <= pose_b_in;
   end

   assign rsp_if.valid                    = rsp_valid_ff;
   assign rsp_if.command_kind             = kind_ff;
   assign rsp_if.forward_speed_hundredths = fwd_ff;
   assign rsp_if.turn_speed_hundredths    = turn_ff;
   assign rsp_if.pose_first               = pose_a_ff;
   assign rsp_if.pose_second              = pose_b_ff;

endmodule

@@ rtl/cfd_checker.sv @@
module cfd_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic [1:0]                             rsp_command_kind,
   input logic signed [cfd_pkg::FWD_WIDTH-1:0]   rsp_fwd,
   input logic signed [cfd_pkg::TURN_WIDTH-1:0]  rsp_turn,
   input logic signed [cfd_pkg::POSE_WIDTH-1:0]  rsp_pose_a,
   input logic signed [cfd_pkg::POSE_WIDTH-1:0]  rsp_pose_b
);

   // a stalled result beat stays up
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // no result right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stop clears every value field
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command_kind == cfd_pkg::KIND_STOP |->
      rsp_fwd == '0 && rsp_turn == '0 && rsp_pose_a == '0 && rsp_pose_b == '0)
      else $error("stop command carries nonzero fields");

   // move has no pose, pose has no speeds
   a_kind_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command_kind == cfd_pkg::KIND_MOVE |->
      rsp_pose_a == '0 && rsp_pose_b == '0)
      else $error("move command carries pose");

   a_pose_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command_kind == cfd_pkg::KIND_POSE |->
      rsp_fwd == '0 && rsp_turn == '0)
      else $error("pose command carries speeds");

endmodule

bind command_frame_deframer_top cfd_checker u_cfd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_command_kind (rsp_if.command_kind),
   .rsp_fwd          (rsp_if.forward_speed_hundredths),
   .rsp_turn         (rsp_if.turn_speed_hundredths),
   .rsp_pose_a       (rsp_if.pose_first),
   .rsp_pose_b       (rsp_if.pose_second)
);
